// File: rtl/core/circular_deque_assert.svh
// ----------------------------------------------------------------------------
// circular_deque_assert.svh
// assertion macros shared by the deque checker
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_ASSERT_SVH
`define CIRCULAR_DEQUE_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define CDQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deque check failed");

// next-cycle implication, sampled on the rising clock edge, off during reset
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deque check failed");

`endif

// File: rtl/core/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// types and constants of the double-ended queue
// ----------------------------------------------------------------------------
package cdq_pkg;

	localparam int unsigned WORD_W = 32;

	// operation requested by one input transfer
	typedef enum logic [1:0] {
		ACT_PUSH_BACK  = 2'd0,
		ACT_PUSH_FRONT = 2'd1,
		ACT_POP_FRONT  = 2'd2,
		ACT_POP_BACK   = 2'd3
	} action_t;

	// result status
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	// command broadcast to every cell of the row
	typedef struct packed {
		logic    en;
		action_t op;
	} cdq_cmd_t;

endpackage

// File: rtl/core/cdq_in_if.sv
// ----------------------------------------------------------------------------
// cdq_in_if
// request channel: one push or pop per transfer
// ----------------------------------------------------------------------------
interface cdq_in_if
	import cdq_pkg::*;
;
	logic                     valid;
	logic                     ready;
	action_t                  action;
	logic signed [WORD_W-1:0] push_value;

	modport source (output valid, output action, output push_value, input ready);
	modport sink   (input valid, input action, input push_value, output ready);
endinterface

// File: rtl/core/cdq_out_if.sv
// ----------------------------------------------------------------------------
// cdq_out_if
// response channel: popped word, status and queue flags
// ----------------------------------------------------------------------------
interface cdq_out_if
	import cdq_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic signed [WORD_W-1:0] pop_value;
	status_t                  status;
	logic                     now_empty;
	logic                     now_full;

	modport source (output valid, output pop_value, output status,
		output now_empty, output now_full, input ready);
	modport sink   (input valid, input pop_value, input status,
		input now_empty, input now_full, output ready);
endinterface

// File: rtl/core/cdq_cell.sv
// ----------------------------------------------------------------------------
// cdq_cell
// one slot of the queue row; elements are kept packed from cell 0 (front)
// ----------------------------------------------------------------------------
module cdq_cell
	import cdq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cdq_cmd_t          cmd,
	input  logic [WORD_W-1:0] push_word,
	input  logic              left_valid,
	input  logic [WORD_W-1:0] left_data,
	input  logic              right_valid,
	input  logic [WORD_W-1:0] right_data,
	output logic              valid,
	output logic              valid_d,
	output logic [WORD_W-1:0] data,
	output logic [WORD_W-1:0] back_word
);
	logic              valid_q;
	logic [WORD_W-1:0] data_q;
	logic [WORD_W-1:0] data_d;

	// next slot contents for each operation
	always_comb begin
		valid_d = valid_q;
		data_d  = data_q;
		if (cmd.en) begin
			case (cmd.op)
				ACT_PUSH_BACK: begin
					if (left_valid && !valid_q) begin
						valid_d = 1'b1;
						data_d  = push_word;
					end
				end
				ACT_PUSH_FRONT: begin
					valid_d = left_valid;
					data_d  = left_data;
				end
				ACT_POP_FRONT: begin
					valid_d = right_valid;
					data_d  = right_data;
				end
				ACT_POP_BACK: begin
					valid_d = valid_q && right_valid;
				end
				default: begin
					valid_d = valid_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	// the last occupied cell offers its word to the back-gather tree
	assign back_word = (valid_q && !right_valid) ? data_q : '0;
	assign valid     = valid_q;
	assign data      = data_q;
endmodule

// File: rtl/core/cdq_gather.sv
// ----------------------------------------------------------------------------
// cdq_gather
// registered or-tree that collects the back element from the cell row
// ----------------------------------------------------------------------------
module cdq_gather
	import cdq_pkg::*;
#(
	parameter int unsigned N = 14
) (
	input  logic                     clk,
	input  logic [N-1:0][WORD_W-1:0] leaf_word,
	output logic [WORD_W-1:0]        root_word
);
	localparam int unsigned LVL = (N > 1) ? $clog2(N) : 0;
	localparam int unsigned P   = 1 << LVL;

	// heap order: node 1 is the root, leaves sit at P .. 2P-1
	logic [WORD_W-1:0]        node_q [1:2*P-1];
	logic [P-1:0][WORD_W-1:0] leaf_pad;

	// leaves padded with zero words up to a power of two
	always_comb begin
		leaf_pad = '0;
		for (int i = 0; i < N; i++) begin
			leaf_pad[i] = leaf_word[i];
		end
	end

	// leaf registers, then one register level per tree level
	always_ff @(posedge clk) begin
		for (int i = 0; i < P; i++) begin
			node_q[P+i] <= leaf_pad[i];
		end
		for (int k = 1; k < P; k++) begin
			node_q[k] <= node_q[2*k] | node_q[2*k+1];
		end
	end

	assign root_word = node_q[1];
endmodule

// File: rtl/core/circular_deque.sv
// ----------------------------------------------------------------------------
// circular_deque
// double-ended queue of DEPTH-2 words held in a row of shifting cells
// ----------------------------------------------------------------------------
// push back, push front, pop front and any overflow or underflow: result in
// the cycle after the transfer; a new request each cycle while results drain.
// pop back: result once the gather state has run through the or-tree levels,
// with the request channel held off until that result is registered.
// arst_n clears the queue to empty; slot contents are not reset.
module circular_deque
	import cdq_pkg::*;
#(
	parameter int unsigned DEPTH = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	cdq_in_if.sink   req,
	cdq_out_if.source rsp
);
	localparam int unsigned N   = DEPTH - 2;
	localparam int unsigned LVL = (N > 1) ? $clog2(N) : 0;
	localparam int unsigned CW  = (LVL > 0) ? $clog2(LVL + 1) : 1;

	typedef enum logic [1:0] {
		S_IDLE   = 2'b01,
		S_GATHER = 2'b10
	} state_t;

	state_t                   state_q;
	logic [CW-1:0]            cnt_q;
	logic                     out_valid_q;
	logic                     out_valid_d;
	logic [WORD_W-1:0]        pop_value_q;
	status_t                  status_q;
	logic                     empty_q;
	logic                     full_q;

	logic [N-1:0]             cell_valid;
	logic [N-1:0]             cell_valid_d;
	logic [N-1:0][WORD_W-1:0] cell_data;
	logic [N-1:0][WORD_W-1:0] cell_back;
	logic [WORD_W-1:0]        root_word;

	cdq_cmd_t                 cmd;
	logic                     take;
	logic                     is_empty;
	logic                     is_full;
	logic                     is_push;
	logic                     req_ok;
	logic                     start_gather;
	logic                     gather_done;

	// request decode
	assign is_empty     = !cell_valid[0];
	assign is_full      = cell_valid[N-1];
	assign take         = req.valid && req.ready;
	assign is_push      = (req.action == ACT_PUSH_BACK) || (req.action == ACT_PUSH_FRONT);
	assign req_ok       = is_push ? !is_full : !is_empty;
	assign start_gather = take && req_ok && (req.action == ACT_POP_BACK);
	assign gather_done  = (state_q == S_GATHER) && (cnt_q == CW'(LVL));

	assign req.ready = (state_q == S_IDLE) && (!out_valid_q || rsp.ready);

	// command to the cell row
	always_comb begin
		cmd.en = 1'b0;
		cmd.op = req.action;
		if (gather_done) begin
			cmd.en = 1'b1;
			cmd.op = ACT_POP_BACK;
		end else if (take && req_ok && (req.action != ACT_POP_BACK)) begin
			cmd.en = 1'b1;
		end
	end

	// cell row
	for (genvar i = 0; i < N; i++) begin : g_cell
		logic              lv;
		logic [WORD_W-1:0] ld;
		logic              rv;
		logic [WORD_W-1:0] rd;

		if (i == 0) begin : g_first
			assign lv = 1'b1;
			assign ld = req.push_value;
		end else begin : g_mid_l
			assign lv = cell_valid[i-1];
			assign ld = cell_data[i-1];
		end

		if (i == N - 1) begin : g_last
			assign rv = 1'b0;
			assign rd = '0;
		end else begin : g_mid_r
			assign rv = cell_valid[i+1];
			assign rd = cell_data[i+1];
		end

		cdq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.push_word   (req.push_value),
			.left_valid  (lv),
			.left_data   (ld),
			.right_valid (rv),
			.right_data  (rd),
			.valid       (cell_valid[i]),
			.valid_d     (cell_valid_d[i]),
			.data        (cell_data[i]),
			.back_word   (cell_back[i])
		);
	end

	cdq_gather #(
		.N (N)
	) u_gather (
		.clk       (clk),
		.leaf_word (cell_back),
		.root_word (root_word)
	);

	// response valid: cleared by a response transfer, set by a new result
	always_comb begin
		out_valid_d = out_valid_q;
		if (rsp.valid && rsp.ready) begin
			out_valid_d = 1'b0;
		end
		if (((state_q == S_IDLE) && take && !start_gather) || gather_done) begin
			out_valid_d = 1'b1;
		end
	end

	// control: gather sequencing and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_valid_d;
			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (start_gather) begin
						state_q <= S_GATHER;
					end
				end
				S_GATHER: begin
					cnt_q <= cnt_q + 1'b1;
					if (gather_done) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (gather_done) begin
			pop_value_q <= root_word;
			status_q    <= ST_OK;
			empty_q     <= !cell_valid_d[0];
			full_q      <= cell_valid_d[N-1];
		end else if (take && !start_gather) begin
			pop_value_q <= (req_ok && (req.action == ACT_POP_FRONT)) ? cell_data[0] : '0;
			status_q    <= req_ok ? ST_OK : (is_push ? ST_OVERFLOW : ST_UNDERFLOW);
			empty_q     <= !cell_valid_d[0];
			full_q      <= cell_valid_d[N-1];
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.pop_value = pop_value_q;
	assign rsp.status    = status_q;
	assign rsp.now_empty = empty_q;
	assign rsp.now_full  = full_q;
endmodule

// File: rtl/core/cdq_checker.sv
// ----------------------------------------------------------------------------
// cdq_checker
// port-level checks on the deque response channel
// ----------------------------------------------------------------------------
`include "circular_deque_assert.svh"

module cdq_checker
	import cdq_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [WORD_W-1:0] rsp_pop_value,
	input logic [1:0]        rsp_status,
	input logic              rsp_now_empty,
	input logic              rsp_now_full
);
	// a stalled response stays offered
	`CDQ_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)

	// overflow only happens on a full queue, which stays full
	`CDQ_ASSERT_IMPLY(a_ovf_full, clk, arst_n, rsp_valid && (rsp_status == ST_OVERFLOW), rsp_now_full && !rsp_now_empty)

	// underflow leaves the queue empty and returns zero
	`CDQ_ASSERT_IMPLY(a_unf_empty, clk, arst_n, rsp_valid && (rsp_status == ST_UNDERFLOW), rsp_now_empty && (rsp_pop_value == '0))

	// empty and full never show together
	`CDQ_ASSERT_IMPLY(a_flags_excl, clk, arst_n, rsp_valid, !(rsp_now_empty && rsp_now_full))
endmodule

bind circular_deque cdq_checker u_cdq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_pop_value (rsp.pop_value),
	.rsp_status    (rsp.status),
	.rsp_now_empty (rsp.now_empty),
	.rsp_now_full  (rsp.now_full)
);
